[hdl/sscav_pkg.sv]
package sscav_pkg;

  localparam int SAMPLE_W = 11;
  localparam int CNT_W    = 4;   // sample_count and taken
  localparam int FS_W     = 16;  // full_scale and level
  localparam int ACC_W    = 14;  // running sum, wraps
  localparam int CORR_W   = 11;  // corrected sample, at most 2047
  localparam int LOW_W    = 8;
  localparam int GAIN_W   = 9;
  localparam int ALU_W    = FS_W;

  localparam logic [LOW_W-1:0]  LOW_OFFSET = 8'd21;
  localparam logic [GAIN_W-1:0] GAIN       = 9'd279;
  localparam int                GAIN_SHIFT = 8;

  localparam logic [CNT_W-1:0] COUNT_RESET = 4'd1;
  localparam logic [FS_W-1:0]  FS_RESET    = 16'd1023;

  // configuration register indexes
  localparam logic REG_SAMPLE_COUNT = 1'b0;
  localparam logic REG_FULL_SCALE   = 1'b1;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } sub_op_t;

  typedef struct packed {
    logic [ALU_W-1:0] diff;
    logic             borrow;
  } sub_res_t;

endpackage

[hdl/sscav_corr.sv]
module sscav_corr (
  input  logic [sscav_pkg::SAMPLE_W-1:0] raw,
  output logic [sscav_pkg::CORR_W-1:0]   corr
);

  logic [sscav_pkg::LOW_W-1:0]                      lo;
  logic [sscav_pkg::LOW_W-1:0]                      lo_off;
  logic [sscav_pkg::LOW_W+sscav_pkg::GAIN_W-1:0]    prod;
  logic [sscav_pkg::LOW_W+sscav_pkg::GAIN_W-1:0]    prod_sh;
  logic [sscav_pkg::CORR_W-1:0]                     trim;

  assign lo      = raw[sscav_pkg::LOW_W-1:0];
  assign lo_off  = lo - sscav_pkg::LOW_OFFSET;
  assign prod    = {{sscav_pkg::GAIN_W{1'b0}}, lo_off} *
                   {{sscav_pkg::LOW_W{1'b0}}, sscav_pkg::GAIN};
  assign prod_sh = prod >> sscav_pkg::GAIN_SHIFT;
  // (234 * 279) >> 8 = 255, so the trim never reaches bit 8
  assign trim    = (lo > sscav_pkg::LOW_OFFSET) ? prod_sh[sscav_pkg::CORR_W-1:0]
                                                : '0;
  assign corr    = {raw[sscav_pkg::SAMPLE_W-1:sscav_pkg::LOW_W],
                    {sscav_pkg::LOW_W{1'b0}}} + trim;

endmodule

[hdl/sscav_sub.sv]
module sscav_sub (
  input  sscav_pkg::sub_op_t  op,
  output sscav_pkg::sub_res_t res
);

  logic [sscav_pkg::ALU_W:0] full;

  assign full       = {1'b0, op.a} - {1'b0, op.b};
  assign res.diff   = full[sscav_pkg::ALU_W-1:0];
  assign res.borrow = full[sscav_pkg::ALU_W];

endmodule

[hdl/sar_sample_correct_average.sv]
// Corrects raw 11-bit converter samples and averages them in groups of
// sample_count (1..MAX_SAMPLES; 0 acts as 1, larger values as MAX_SAMPLES).
// Pulse start while busy is low to hand in one sample; the block then stays
// busy to correct and accumulate it, and on the sample that closes its group
// also for restoring division of the 14-bit sum by the count through the
// shared subtractor and for full_scale minus the average on that same
// subtractor. A result is shown on level/underflow for exactly one cycle
// with done high; it must be taken then, there is no way to stall it. When
// the average exceeds full_scale, level is 0 and underflow is 1. Write
// configuration only while busy is low.
module sar_sample_correct_average #(
  parameter int MAX_SAMPLES = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [sscav_pkg::SAMPLE_W-1:0] sample,
  output logic                          done,
  output logic [sscav_pkg::FS_W-1:0]    level,
  output logic                          underflow,
  input  logic                          cfg_we,
  input  logic                          cfg_idx,
  input  logic [sscav_pkg::FS_W-1:0]    cfg_wdata
);

  localparam int RW     = $clog2(MAX_SAMPLES + 1);
  localparam int STEP_W = $clog2(sscav_pkg::ACC_W);
  localparam logic [sscav_pkg::CNT_W-1:0] MAX_N = sscav_pkg::CNT_W'(MAX_SAMPLES);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(sscav_pkg::ACC_W - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CORR = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]                      state;
  logic [sscav_pkg::CNT_W-1:0]     sample_count;
  logic [sscav_pkg::FS_W-1:0]      full_scale;
  logic [sscav_pkg::ACC_W-1:0]     acc;
  logic [sscav_pkg::CNT_W-1:0]     taken;
  logic [sscav_pkg::SAMPLE_W-1:0]  smp;
  logic [RW-1:0]                   rem;
  logic [STEP_W-1:0]               step;

  logic [sscav_pkg::CNT_W-1:0]     n;
  logic [sscav_pkg::CORR_W-1:0]    corr;
  logic [sscav_pkg::ACC_W-1:0]     acc_sum;
  logic [sscav_pkg::CNT_W-1:0]     taken_sum;
  logic [RW:0]                     trial;
  sscav_pkg::sub_op_t              op;
  sscav_pkg::sub_res_t             res;

  assign busy = (state != ST_IDLE);

  always_comb begin
    if (sample_count == '0) begin
      n = sscav_pkg::CNT_W'(1);
    end else if (sample_count > MAX_N) begin
      n = MAX_N;
    end else begin
      n = sample_count;
    end
  end

  sscav_corr u_corr (
    .raw  (smp),
    .corr (corr)
  );

  assign acc_sum   = acc + sscav_pkg::ACC_W'(corr);
  assign taken_sum = taken + sscav_pkg::CNT_W'(1);
  assign trial     = {rem, acc[sscav_pkg::ACC_W-1]};

  // shared subtractor: division step, or full_scale minus quotient
  always_comb begin
    if (state == ST_DIV) begin
      op.a = sscav_pkg::ALU_W'(trial);
      op.b = sscav_pkg::ALU_W'(n);
    end else begin
      op.a = full_scale;
      op.b = sscav_pkg::ALU_W'(acc);
    end
  end

  sscav_sub u_sub (
    .op  (op),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sample_count <= sscav_pkg::COUNT_RESET;
      full_scale   <= sscav_pkg::FS_RESET;
      acc          <= '0;
      taken        <= '0;
      done         <= 1'b0;
    end else begin
      done <= (state == ST_FIN);
      if (cfg_we) begin
        unique case (cfg_idx)
          sscav_pkg::REG_SAMPLE_COUNT: sample_count <= cfg_wdata[sscav_pkg::CNT_W-1:0];
          sscav_pkg::REG_FULL_SCALE:   full_scale   <= cfg_wdata;
          default:                     ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            smp   <= sample;
            state <= ST_CORR;
          end
        end
        ST_CORR: begin
          acc   <= acc_sum;
          taken <= taken_sum;
          if (taken_sum < n) begin
            state <= ST_IDLE;
          end else begin
            rem   <= '0;
            step  <= LAST_STEP;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          // quotient bits shift into acc from the bottom
          rem  <= res.borrow ? trial[RW-1:0] : res.diff[RW-1:0];
          acc  <= {acc[sscav_pkg::ACC_W-2:0], ~res.borrow};
          step <= step - STEP_W'(1);
          if (step == '0) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          level     <= res.borrow ? '0 : res.diff;
          underflow <= res.borrow;
          acc       <= '0;
          taken     <= '0;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[hdl/sscav_chk.sv]
module sscav_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic [sscav_pkg::FS_W-1:0] level,
  input logic                       underflow
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while still busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    done && underflow |-> level == '0)
    else $error("underflow with nonzero level");

endmodule

bind sar_sample_correct_average sscav_chk u_sscav_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .level     (level),
  .underflow (underflow)
);
